[design/ptda_pkg.sv]
// -----------------------------------------------------------------------------
// ptda_pkg - shared types and constants of the panned tap delay accumulator
// Payload words of both channels, the word that travels from the front end to
// the back end, register indexes, command codes and back end states.
// -----------------------------------------------------------------------------
`default_nettype none

package ptda_pkg;

   // Field widths
   localparam int POS_W    = 13;  // positions below the widest usable line length
   localparam int LEN_W    = 13;
   localparam int CHAN_W   = 2;
   localparam int MGAIN_W  = 16;
   localparam int TGAIN_W  = 15;
   localparam int DELAY_W  = 16;
   localparam int PAN_W    = 16;
   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = TGAIN_W + MGAIN_W;
   localparam int SHARE_W  = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Shares above unity are capped before they are added
   localparam logic [SHARE_W-1:0] SHARE_CAP = 17'd65536;

   // Register reset values
   localparam logic [CHAN_W-1:0]  CHANNELS_RST    = 2'd2;
   localparam logic [MGAIN_W-1:0] MASTER_GAIN_RST = 16'd4096;
   localparam logic [LEN_W-1:0]   LINE_LENGTH_RST = 13'd4096;

   // Work queue between front end and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Command codes
   localparam logic CMD_TAP  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHANNELS    = 2'd0,
      CSR_MASTER_GAIN = 2'd1,
      CSR_LINE_LENGTH = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_FETCH,
      BK_APPLY
   } back_state_type;

   typedef struct packed {
      logic                       cmd;
      logic [DELAY_W-1:0]         delay_samples;
      logic signed [PAN_W-1:0]    direction_x;
      logic [TGAIN_W-1:0]         tap_gain;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_left;
      logic signed [SAMPLE_W-1:0] sample_right;
   } rsp_type;

   typedef struct packed {
      logic               tick;
      logic               stereo;
      logic [POS_W-1:0]   addr;
      logic [SHARE_W-1:0] share0;
      logic [SHARE_W-1:0] share1;
   } work_type;

endpackage

`default_nettype wire

[design/panned_tap_delay_accumulator.sv]
// -----------------------------------------------------------------------------
// panned_tap_delay_accumulator - multi-tap accumulating delay line, linear pan
// Requests enter as queue words: push with full, taken when push is high and
// full is low. A tap word adds its panned, scaled gain into one or two lines
// at the write position plus its delay; a tick word yields one result word.
// Results leave as queue words: the oldest sits on rsp_data while rsp_empty is
// low and is taken when rsp_pop is high. Registers are written through the
// csr_ channel (always ready); the user must write them only while the block
// is idle, which the block itself does not enforce. A tick's result passes
// the classify stage, the work queue, the line read and the result slot in
// that order. The back end reads and then writes each line memory's single
// port pair for every word; a four-word work queue and a classify stage let
// the front keep taking words meanwhile. Reset: registers return to stereo,
// unity master gain and a 4096 line; the lines are then swept to zero, with
// full held high. A stalled receiver holds the result slot: taps keep running,
// and the next tick waits in the queue until the slot is taken; full rises
// when the queue and the classify stage are both occupied.
// -----------------------------------------------------------------------------
`default_nettype none

module panned_tap_delay_accumulator #(
   parameter int LINE_DEPTH   = 4096,
   parameter int MAX_CHANNELS = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  ptda_pkg::req_type               req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output ptda_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ptda_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ptda_pkg::CSR_DATA_W-1:0] csr_data
);
   import ptda_pkg::*;

   logic     clear_busy;
   logic     work_push, work_full, work_pop, work_empty;
   work_type work_in, work_head;

   // Front end: registers, write position, classification
   ptda_front #(
      .LINE_DEPTH   (LINE_DEPTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .clear_busy (clear_busy),
      .work_push  (work_push),
      .work_full  (work_full),
      .work_data  (work_in)
   );

   // Decouple the two halves
   ptda_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (work_in),
      .full      (work_full),
      .pop       (work_pop),
      .empty     (work_empty),
      .head      (work_head)
   );

   // Back end: line memories and result slot
   ptda_back #(
      .LINE_DEPTH   (LINE_DEPTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .work_empty (work_empty),
      .work_pop   (work_pop),
      .work_data  (work_head),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data),
      .clear_busy (clear_busy)
   );

   // Checks
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      work_full |-> !work_push)
      else $error("work queue written while full");

   a_queue_no_underflow: assert property (@(posedge clock) disable iff (reset)
      work_empty |-> !work_pop)
      else $error("work queue read while empty");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> clear_busy)
      else $error("line sweep did not start after reset");

   a_clear_blocks_work: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> (req_full && !work_pop))
      else $error("word taken during line sweep");

endmodule

`default_nettype wire

[design/ptda_front.sv]
// -----------------------------------------------------------------------------
// ptda_front - accepts request words and turns them into work words
// Holds the registers and the shared write position, resolves the line address
// of each word, and splits the scaled tap gain into per-channel shares.
// -----------------------------------------------------------------------------
`default_nettype none

module ptda_front #(
   parameter int LINE_DEPTH   = 4096,
   parameter int MAX_CHANNELS = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  ptda_pkg::req_type                    req_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ptda_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ptda_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                 clear_busy,
   output logic                                 work_push,
   input  logic                                 work_full,
   output ptda_pkg::work_type                   work_data
);
   import ptda_pkg::*;

   localparam logic [16:0] DEPTH_CAP = 17'(LINE_DEPTH);
   localparam int PROD_W = GAIN_W + SHARE_W;
   localparam logic [PROD_W-1:0] PAN_ROUND  = PROD_W'(1) << 27;
   localparam logic [GAIN_W:0]   MONO_ROUND = (GAIN_W+1)'(2048);

   // Cap a rounded share at unity
   function automatic logic [SHARE_W-1:0] cap_share(input logic [19:0] v);
      logic [SHARE_W-1:0] r;
      if (v > 20'(SHARE_CAP)) r = SHARE_CAP;
      else r = v[SHARE_W-1:0];
      return r;
   endfunction

   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic [MGAIN_W-1:0] master_ff, master_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [POS_W-1:0]   wp_ff, wp_in;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_tick_ff, s1_tick_in;
   logic               s1_stereo_ff, s1_stereo_in;
   logic [POS_W-1:0]   s1_addr_ff, s1_addr_in;
   logic [GAIN_W-1:0]  s1_gain_ff, s1_gain_in;
   logic [PAN_W-1:0]   s1_pan_ff, s1_pan_in;

   logic [16:0]        len_wide;
   logic [POS_W-1:0]   eff_len;
   logic [POS_W-1:0]   wp_eff;
   logic [POS_W-1:0]   last_pos;
   logic [POS_W-1:0]   delay_clamped;
   logic [POS_W:0]     tap_sum;
   logic [POS_W-1:0]   tap_pos;
   logic [POS_W:0]     tick_sum;
   logic [POS_W-1:0]   wp_next;
   logic               stereo;
   logic               accept;

   logic [PAN_W:0]     q_pan;
   logic [PROD_W-1:0]  prod_l, prod_r;
   logic [PROD_W-1:0]  round_l, round_r;
   logic [GAIN_W:0]    mono_sum;
   logic [SHARE_W-1:0] share_l, share_r, share_m;

   assign csr_ready = 1'b1;

   // Register writes
   always_comb begin
      chan_in   = chan_ff;
      master_in = master_ff;
      len_in    = len_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CHANNELS:    chan_in   = csr_data[CHAN_W-1:0];
            CSR_MASTER_GAIN: master_in = csr_data[MGAIN_W-1:0];
            CSR_LINE_LENGTH: len_in    = csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective length: at least one, at most the line depth
   always_comb begin
      len_wide = {4'd0, len_ff};
      if (len_wide == 17'd0) len_wide = 17'd1;
      if (len_wide > DEPTH_CAP) len_wide = DEPTH_CAP;
      eff_len = len_wide[POS_W-1:0];
   end

   assign stereo = (MAX_CHANNELS > 1) && (chan_ff >= 2'd2);

   // Resolve positions; a stale position past the line end restarts at zero
   always_comb begin
      wp_eff   = (wp_ff >= eff_len) ? '0 : wp_ff;
      last_pos = eff_len - 1'b1;
      if (req_data.delay_samples > {3'd0, last_pos}) delay_clamped = last_pos;
      else delay_clamped = req_data.delay_samples[POS_W-1:0];
      tap_sum = {1'b0, wp_eff} + {1'b0, delay_clamped};
      if (tap_sum >= {1'b0, eff_len}) tap_pos = POS_W'(tap_sum - {1'b0, eff_len});
      else tap_pos = tap_sum[POS_W-1:0];
      tick_sum = {1'b0, wp_eff} + 1'b1;
      if (tick_sum >= {1'b0, eff_len}) wp_next = '0;
      else wp_next = tick_sum[POS_W-1:0];
   end

   assign accept    = req_push && !req_full;
   assign req_full  = clear_busy || (s1_valid_ff && work_full);
   assign work_push = s1_valid_ff && !work_full;

   // Load the classify stage and advance the write position on a tick
   always_comb begin
      wp_in        = wp_ff;
      s1_valid_in  = work_push ? 1'b0 : s1_valid_ff;
      s1_tick_in   = s1_tick_ff;
      s1_stereo_in = s1_stereo_ff;
      s1_addr_in   = s1_addr_ff;
      s1_gain_in   = s1_gain_ff;
      s1_pan_in    = s1_pan_ff;
      if (accept) begin
         s1_valid_in  = 1'b1;
         s1_tick_in   = (req_data.cmd == CMD_TICK);
         s1_stereo_in = stereo;
         s1_gain_in   = {{MGAIN_W{1'b0}}, req_data.tap_gain} * {{TGAIN_W{1'b0}}, master_ff};
         // pan = x + 0.5 in units of 2^-16 is the raw word with its sign flipped
         s1_pan_in    = req_data.direction_x ^ 16'h8000;
         if (req_data.cmd == CMD_TICK) begin
            s1_addr_in = wp_eff;
            wp_in      = wp_next;
         end else begin
            s1_addr_in = tap_pos;
            wp_in      = wp_eff;
         end
      end
   end

   // Split the scaled gain into channel shares
   always_comb begin
      q_pan    = 17'd65536 - {1'b0, s1_pan_ff};
      prod_l   = {{SHARE_W{1'b0}}, s1_gain_ff} * {{GAIN_W{1'b0}}, q_pan};
      prod_r   = {{SHARE_W{1'b0}}, s1_gain_ff} * {{(GAIN_W+1){1'b0}}, s1_pan_ff};
      round_l  = prod_l + PAN_ROUND;
      round_r  = prod_r + PAN_ROUND;
      mono_sum = {1'b0, s1_gain_ff} + MONO_ROUND;
      share_l  = cap_share(round_l[47:28]);
      share_r  = cap_share(round_r[47:28]);
      share_m  = cap_share(mono_sum[31:12]);
   end

   always_comb begin
      work_data.tick   = s1_tick_ff;
      work_data.stereo = s1_stereo_ff;
      work_data.addr   = s1_addr_ff;
      work_data.share0 = s1_stereo_ff ? share_l : share_m;
      work_data.share1 = s1_stereo_ff ? share_r : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff     <= CHANNELS_RST;
         master_ff   <= MASTER_GAIN_RST;
         len_ff      <= LINE_LENGTH_RST;
         wp_ff       <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         chan_ff     <= chan_in;
         master_ff   <= master_in;
         len_ff      <= len_in;
         wp_ff       <= wp_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tick_ff   <= s1_tick_in;
      s1_stereo_ff <= s1_stereo_in;
      s1_addr_ff   <= s1_addr_in;
      s1_gain_ff   <= s1_gain_in;
      s1_pan_ff    <= s1_pan_in;
   end

endmodule

`default_nettype wire

[design/ptda_queue.sv]
// -----------------------------------------------------------------------------
// ptda_queue - short work queue between front end and back end
// A small circular buffer of work words; the head word is shown while the
// queue holds anything.
// -----------------------------------------------------------------------------
`default_nettype none

module ptda_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ptda_pkg::work_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output ptda_pkg::work_type head
);
   import ptda_pkg::*;

   work_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // Advance pointers and track the fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

[design/ptda_back.sv]
// -----------------------------------------------------------------------------
// ptda_back - executes work words against the accumulation lines
// One line memory per channel, read in the fetch state and written in the
// apply state: a tap adds its share with saturation, a tick emits and clears
// the entry. After reset the lines are swept to zero, one address a cycle.
// -----------------------------------------------------------------------------
`default_nettype none

module ptda_back #(
   parameter int LINE_DEPTH   = 4096,
   parameter int MAX_CHANNELS = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               work_empty,
   output logic               work_pop,
   input  ptda_pkg::work_type work_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output ptda_pkg::rsp_type  rsp_data,
   output logic               clear_busy
);
   import ptda_pkg::*;

   localparam int ADDR_W = $clog2(LINE_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LINE_DEPTH - 1);

   // Add a share to an entry, saturating at the Q1.15 limits
   function automatic logic signed [SAMPLE_W-1:0] sat_add(
      input logic signed [SAMPLE_W-1:0] entry,
      input logic [SHARE_W-1:0]         share
   );
      logic signed [SAMPLE_W+2:0] sum;
      logic signed [SAMPLE_W-1:0] r;
      sum = {{3{entry[SAMPLE_W-1]}}, entry} + {2'b00, share};
      if (sum > 19'sd32767) r = 16'sh7fff;
      else if (sum < -19'sd32768) r = 16'sh8000;
      else r = sum[SAMPLE_W-1:0];
      return r;
   endfunction

   back_state_type              state_ff, state_in;
   logic [ADDR_W-1:0]           clr_ff, clr_in;
   work_type                    op_ff, op_in;
   logic                        out_valid_ff, out_valid_in;
   rsp_type                     out_ff, out_in;

   logic                        fetch_go;
   logic [ADDR_W-1:0]           rd_addr;
   logic [ADDR_W-1:0]           wr_addr;
   logic                        wr_en0, wr_en1;
   logic signed [SAMPLE_W-1:0]  wr_data0, wr_data1;
   logic signed [SAMPLE_W-1:0]  rd0_ff;
   logic signed [SAMPLE_W-1:0]  rd1_data;
   logic signed [SAMPLE_W-1:0]  line0_mem [LINE_DEPTH];

   // Take a word when one waits; a tick also needs the result slot free
   assign fetch_go = (state_ff == BK_FETCH) && !work_empty &&
                     (!work_data.tick || !out_valid_ff || rsp_pop);
   assign work_pop   = fetch_go;
   assign rd_addr    = ADDR_W'(work_data.addr);
   assign clear_busy = (state_ff == BK_CLEAR);
   assign rsp_empty  = !out_valid_ff;
   assign rsp_data   = out_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: if (clr_ff == LAST_ADDR) state_in = BK_FETCH;
         BK_FETCH: if (fetch_go) state_in = BK_APPLY;
         BK_APPLY: state_in = BK_FETCH;
         default:  state_in = BK_CLEAR;
      endcase
   end

   // Memory writes and result slot
   always_comb begin
      clr_in       = clr_ff;
      op_in        = fetch_go ? work_data : op_ff;
      wr_addr      = ADDR_W'(op_ff.addr);
      wr_en0       = 1'b0;
      wr_en1       = 1'b0;
      wr_data0     = '0;
      wr_data1     = '0;
      out_valid_in = rsp_pop ? 1'b0 : out_valid_ff;
      out_in       = out_ff;
      case (state_ff)
         BK_CLEAR: begin
            clr_in  = clr_ff + 1'b1;
            wr_addr = clr_ff;
            wr_en0  = 1'b1;
            wr_en1  = 1'b1;
         end
         BK_APPLY: begin
            wr_en0 = 1'b1;
            wr_en1 = op_ff.stereo;
            if (op_ff.tick) begin
               out_valid_in        = 1'b1;
               out_in.sample_left  = rd0_ff;
               out_in.sample_right = op_ff.stereo ? rd1_data : '0;
            end else begin
               wr_data0 = sat_add(rd0_ff, op_ff.share0);
               wr_data1 = sat_add(rd1_data, op_ff.share1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      out_ff <= out_in;
   end

   // Channel 0 line
   always_ff @(posedge clock) begin
      if (wr_en0) line0_mem[wr_addr] <= wr_data0;
      if (fetch_go) rd0_ff <= line0_mem[rd_addr];
   end

   // Channel 1 line, present only when built for two channels
   generate
      if (MAX_CHANNELS > 1) begin : g_line1
         logic signed [SAMPLE_W-1:0] rd1_ff;
         logic signed [SAMPLE_W-1:0] line1_mem [LINE_DEPTH];
         always_ff @(posedge clock) begin
            if (wr_en1) line1_mem[wr_addr] <= wr_data1;
            if (fetch_go) rd1_ff <= line1_mem[rd_addr];
         end
         assign rd1_data = rd1_ff;
      end else begin : g_no_line1
         assign rd1_data = '0;
      end
   endgenerate

endmodule

`default_nettype wire
